// File: rtl/core/blm_pkg.sv
package blm_pkg;

    localparam int CODE_W    = 12;
    localparam int LEVEL_W   = 20;
    localparam int MV_W      = 14;
    localparam int CFG_IDX_W = 2;

    localparam int SAMPLES_DEFAULT = 10;

    localparam logic [1:0] OP_SAMPLE       = 2'd0;
    localparam logic [1:0] OP_FORCE_LOW    = 2'd1;
    localparam logic [1:0] OP_FORCE_NORMAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_THRESHOLD = 2'd2;

    localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST    = 20'd360029;
    localparam logic [LEVEL_W-1:0] NORMAL_THRESHOLD_RST = 20'd381207;
    localparam logic [LEVEL_W-1:0] CHARGE_THRESHOLD_RST = 20'd423564;

    // divide by 10 of a 24-bit filter numerator: multiply by reciprocal
    localparam int FILT_NUM_W = 24;
    localparam int FILT_SH    = 28;
    localparam int FILT_MW    = 25;
    localparam logic [FILT_MW-1:0] FILT_M = FILT_MW'(((64'd1 << FILT_SH) + 64'd9) / 64'd10);

    // mV = floor(level * 55 / 5824) = floor(floor(level * 55 / 64) / 91)
    localparam int MV_SCALE_W = 6;
    localparam logic [MV_SCALE_W-1:0] MV_SCALE = 6'd55;
    localparam int MV_PRE_SH  = 6;
    localparam int MV_SH      = 27;
    localparam int MV_MW      = 21;
    localparam logic [MV_MW-1:0] MV_M = MV_MW'(((64'd1 << MV_SH) + 64'd90) / 64'd91);

    typedef struct packed {
        logic [1:0]        operation;
        logic [CODE_W-1:0] adc_sample;
    } in_item_t;

    typedef struct packed {
        logic               battery_low;
        logic               charging;
        logic [LEVEL_W-1:0] level_code;
        logic [MV_W-1:0]    level_millivolts;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_BATCH,
        KIND_FORCE_LOW,
        KIND_FORCE_NORMAL
    } kind_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [LEVEL_W-1:0] level;
    } flt_out_t;

endpackage

// File: rtl/core/blm_filter.sv
module blm_filter
    import blm_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  logic     item_valid,
    input  in_item_t item,
    output flt_out_t result
);

    localparam int SUM_W   = $clog2(SAMPLES * 4095 + 1);
    localparam int CNT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int AVG_SH  = SUM_W + $clog2(SAMPLES);
    localparam int AVG_MW  = AVG_SH + 1;
    localparam int AVG_PW  = SUM_W + AVG_MW;
    localparam int FILT_PW = FILT_NUM_W + FILT_MW;
    localparam logic [CNT_W-1:0]  LAST  = CNT_W'(SAMPLES - 1);
    localparam logic [AVG_MW-1:0] AVG_M =
        AVG_MW'(((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    logic [SUM_W-1:0]   sum_reg, sum_next, total;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               s1_valid_reg, s1_valid_next;
    kind_t              s1_kind_reg, s1_kind_next;
    logic [SUM_W-1:0]   s1_sum_reg;
    logic               s2_valid_reg;
    kind_t              s2_kind_reg;
    logic [CODE_W-1:0]  s2_avg_reg, avg;
    logic [AVG_PW-1:0]  avg_prod;
    logic [LEVEL_W-1:0] level_reg, level_next, level_filt, level_prime;
    logic [FILT_NUM_W-1:0] filt_num;
    logic [FILT_PW-1:0] filt_prod;
    logic               s3_valid_reg;
    kind_t              s3_kind_reg;
    logic [LEVEL_W-1:0] s3_level_reg;

    // accumulate a batch
    assign total = sum_reg + SUM_W'(item.adc_sample);

    always_comb
    begin
        sum_next      = sum_reg;
        count_next    = count_reg;
        s1_valid_next = 1'b0;
        s1_kind_next  = KIND_BATCH;
        if (item_valid)
        begin
            case (item.operation)
                OP_SAMPLE:
                begin
                    if (count_reg == LAST)
                    begin
                        s1_valid_next = 1'b1;
                        sum_next      = '0;
                        count_next    = '0;
                    end
                    else
                    begin
                        sum_next   = total;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_FORCE_LOW:
                begin
                    s1_valid_next = 1'b1;
                    s1_kind_next  = KIND_FORCE_LOW;
                end
                OP_FORCE_NORMAL:
                begin
                    s1_valid_next = 1'b1;
                    s1_kind_next  = KIND_FORCE_NORMAL;
                end
                default:
                begin
                end
            endcase
        end
    end

    // batch average
    assign avg_prod = AVG_PW'(s1_sum_reg) * AVG_PW'(AVG_M);
    assign avg      = avg_prod[AVG_SH +: CODE_W];

    // low-pass filter: (9*level + 256*avg) / 10
    assign filt_num    = (FILT_NUM_W'(level_reg) << 3) + FILT_NUM_W'(level_reg)
                       + (FILT_NUM_W'(s2_avg_reg) << 8);
    assign filt_prod   = FILT_PW'(filt_num) * FILT_PW'(FILT_M);
    assign level_filt  = filt_prod[FILT_SH +: LEVEL_W];
    assign level_prime = {s2_avg_reg, 8'd0};

    always_comb
    begin
        level_next = level_reg;
        if (s2_valid_reg && (s2_kind_reg == KIND_BATCH))
        begin
            if (level_reg == '0)
            begin
                level_next = level_prime;
            end
            else
            begin
                level_next = level_filt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            level_reg    <= '0;
        end
        else if (advance)
        begin
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            level_reg    <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg  <= s1_kind_next;
            s1_sum_reg   <= total;
            s2_kind_reg  <= s1_kind_reg;
            s2_avg_reg   <= avg;
            s3_kind_reg  <= s2_kind_reg;
            s3_level_reg <= level_next;
        end
    end

    assign result.valid = s3_valid_reg;
    assign result.kind  = s3_kind_reg;
    assign result.level = s3_level_reg;

endmodule

// File: rtl/core/battery_level_monitor.sv
// Items pass the s0 input register, filter s1-s3, s4, s5 and output register.
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Sample items inside a batch and operation code 3 produce no result.
// Reset (async, active low) clears the accumulator, filtered level, low and
// charging flags, all stage valids, and loads the default thresholds.
module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data
);

    localparam int MV_PRE_PW = LEVEL_W + MV_SCALE_W;
    localparam int MV_PW     = LEVEL_W + MV_MW;

    logic               advance;
    logic               s0_valid_reg;
    in_item_t           s0_item_reg;
    flt_out_t           flt;

    logic [LEVEL_W-1:0] low_thr_reg, normal_thr_reg, charge_thr_reg;
    logic               low_reg, low_next;
    logic               charging_reg, charging_next;

    logic               s4_valid_reg;
    logic               s4_low_reg, s4_charging_reg;
    logic [LEVEL_W-1:0] s4_level_reg;

    logic [MV_PRE_PW-1:0] mv_pre_prod;
    logic               s5_valid_reg;
    logic               s5_low_reg, s5_charging_reg;
    logic [LEVEL_W-1:0] s5_level_reg, s5_pre_reg;

    logic [MV_PW-1:0]   mv_prod;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg    <= LOW_THRESHOLD_RST;
            normal_thr_reg <= NORMAL_THRESHOLD_RST;
            charge_thr_reg <= CHARGE_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOW_THRESHOLD:    low_thr_reg    <= cfg_data;
                REG_NORMAL_THRESHOLD: normal_thr_reg <= cfg_data;
                REG_CHARGE_THRESHOLD: charge_thr_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    blm_filter #(
        .SAMPLES (SAMPLES)
    ) u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (s0_valid_reg),
        .item       (s0_item_reg),
        .result     (flt)
    );

    // classification with hysteresis, force operations
    always_comb
    begin
        low_next      = low_reg;
        charging_next = charging_reg;
        if (flt.valid)
        begin
            case (flt.kind)
                KIND_BATCH:
                begin
                    if (flt.level > charge_thr_reg)
                    begin
                        charging_next = 1'b1;
                        low_next      = 1'b0;
                    end
                    else if (flt.level < low_thr_reg)
                    begin
                        charging_next = 1'b0;
                        low_next      = 1'b1;
                    end
                    else if (flt.level > normal_thr_reg)
                    begin
                        charging_next = 1'b0;
                        low_next      = 1'b0;
                    end
                end
                KIND_FORCE_LOW:    low_next = 1'b1;
                KIND_FORCE_NORMAL: low_next = 1'b0;
                default:
                begin
                end
            endcase
        end
    end

    assign mv_pre_prod = MV_PRE_PW'(s4_level_reg) * MV_PRE_PW'(MV_SCALE);
    assign mv_prod     = MV_PW'(s5_pre_reg) * MV_PW'(MV_M);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            low_reg       <= 1'b0;
            charging_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg  <= in_valid;
            low_reg       <= low_next;
            charging_reg  <= charging_next;
            s4_valid_reg  <= flt.valid;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_item_reg                   <= in_item;
            s4_low_reg                    <= low_next;
            s4_charging_reg               <= charging_next;
            s4_level_reg                  <= flt.level;
            s5_low_reg                    <= s4_low_reg;
            s5_charging_reg               <= s4_charging_reg;
            s5_level_reg                  <= s4_level_reg;
            s5_pre_reg                    <= mv_pre_prod[MV_PRE_SH +: LEVEL_W];
            out_item_reg.battery_low      <= s5_low_reg;
            out_item_reg.charging         <= s5_charging_reg;
            out_item_reg.level_code       <= s5_level_reg;
            out_item_reg.level_millivolts <= mv_prod[MV_SH +: MV_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import blm_pkg::*;

    localparam int BATCH          = SAMPLES_DEFAULT;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 255;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [1:0]           OP_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;
    localparam logic [LEVEL_W-1:0]   FULL_LEVEL  = 20'd1048320;
    localparam logic [MV_W-1:0]      FULL_MV     = 14'd9900;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } step_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_item;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEVEL_W-1:0]   cfg_data = '0;

    // battery state as the block should hold it
    logic [31:0]        acc_sum     = '0;
    int unsigned        acc_count   = 0;
    logic [LEVEL_W-1:0] filt_level  = '0;
    logic               state_low   = 1'b0;
    logic               charge_flag = 1'b0;
    logic [LEVEL_W-1:0] thr_low     = LOW_THRESHOLD_RST;
    logic [LEVEL_W-1:0] thr_normal  = NORMAL_THRESHOLD_RST;
    logic [LEVEL_W-1:0] thr_charge  = CHARGE_THRESHOLD_RST;

    out_item_t   pending_readings[$];
    out_item_t   head;
    step_row_t   opening_rows[$];
    int          errors = 0;
    int unsigned quiet_cycles = 0;
    int          drift = 1500;
    bit          idle_in = 1'b1;
    bit          idle_out = 1'b1;
    bit          hold_out = 1'b0;

    battery_level_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit next_reading(input in_item_t it, output out_item_t res);
        logic [31:0] avg_code;
        logic [31:0] target;
        logic [63:0] mv;
        bit          produced;
        produced = 1'b0;
        case (it.operation)
            OP_FORCE_LOW:
            begin
                state_low = 1'b1;
                produced  = 1'b1;
            end
            OP_FORCE_NORMAL:
            begin
                state_low = 1'b0;
                produced  = 1'b1;
            end
            OP_SAMPLE:
            begin
                acc_sum   = acc_sum + 32'(it.adc_sample);
                acc_count = acc_count + 1;
                if (acc_count == BATCH)
                begin
                    avg_code = acc_sum / BATCH;
                    target   = avg_code * 256;
                    if (filt_level == '0)
                        filt_level = target[LEVEL_W-1:0];
                    else
                        filt_level = LEVEL_W'((32'd9 * 32'(filt_level) + target) / 32'd10);
                    acc_sum   = '0;
                    acc_count = 0;
                    if (filt_level > thr_charge)
                    begin
                        charge_flag = 1'b1;
                        state_low   = 1'b0;
                    end
                    else if (filt_level < thr_low)
                    begin
                        charge_flag = 1'b0;
                        state_low   = 1'b1;
                    end
                    else if (filt_level > thr_normal)
                    begin
                        charge_flag = 1'b0;
                        state_low   = 1'b0;
                    end
                    produced = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        mv = 64'(filt_level) * 64'd9900 / 64'(FULL_LEVEL);
        res.battery_low      = state_low;
        res.charging         = charge_flag;
        res.level_code       = filt_level;
        res.level_millivolts = mv[MV_W-1:0];
        return produced;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned pick;
        int          code;
        pick          = $urandom_range(0, 99);
        it.operation  = OP_SAMPLE;
        it.adc_sample = CODE_W'($urandom);
        if (pick < 3)
            it.operation = OP_FORCE_LOW;
        else if (pick < 6)
            it.operation = OP_FORCE_NORMAL;
        else if (pick < 8)
            it.operation = OP_RESERVED;
        else if (pick >= 16)
        begin
            // slow drift around the thresholds, with occasional jumps
            if ($urandom_range(0, 49) == 0)
                drift = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 4095))
                                                    : int'($urandom_range(1300, 1750));
            else
                drift = drift + int'($urandom_range(0, 40)) - 20;
            if (drift < 0)
                drift = 0;
            if (drift > 4095)
                drift = 4095;
            code = drift + int'($urandom_range(0, 32)) - 16;
            if (code < 0)
                code = 0;
            if (code > 4095)
                code = 4095;
            it.adc_sample = CODE_W'(code);
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        int unsigned gap;
        out_item_t   predicted;
        gap = idle_in ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        if (next_reading(it, predicted))
            pending_readings.push_back(typed ? want : predicted);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_LOW_THRESHOLD:    thr_low    = val;
            REG_NORMAL_THRESHOLD: thr_normal = val;
            REG_CHARGE_THRESHOLD: thr_charge = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic report_field(input string field, input longint unsigned want_v,
                                input longint unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
        end
    endtask

    initial
    begin : sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
            end
            stall = idle_out ? $urandom_range(0, 9) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, actual %h", $time, out_item);
            end
            else
            begin
                head = pending_readings.pop_front();
                report_field("battery_low", 64'(head.battery_low),
                             64'(out_item.battery_low));
                report_field("charging", 64'(head.charging), 64'(out_item.charging));
                report_field("level_code", 64'(head.level_code), 64'(out_item.level_code));
                report_field("level_millivolts", 64'(head.level_millivolts),
                             64'(out_item.level_millivolts));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        step_row_t   row;
        in_item_t    it;
        int unsigned n;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // zero batch leaves the level unprimed; full-scale batch primes it
        for (int k = 0; k < BATCH; k++)
        begin
            row.item  = {OP_SAMPLE, 12'd0};
            row.typed = (k == BATCH - 1);
            row.want  = {1'b1, 1'b0, 20'd0, 14'd0};
            opening_rows.push_back(row);
        end
        for (int k = 0; k < BATCH; k++)
        begin
            row.item  = {OP_SAMPLE, 12'hFFF};
            row.typed = (k == BATCH - 1);
            row.want  = {1'b0, 1'b1, FULL_LEVEL, FULL_MV};
            opening_rows.push_back(row);
        end
        row.item  = {OP_FORCE_LOW, 12'hFFF};
        row.typed = 1'b1;
        row.want  = {1'b1, 1'b1, FULL_LEVEL, FULL_MV};
        opening_rows.push_back(row);
        row.item  = {OP_FORCE_NORMAL, 12'h000};
        row.typed = 1'b1;
        row.want  = {1'b0, 1'b1, FULL_LEVEL, FULL_MV};
        opening_rows.push_back(row);
        row.item  = {OP_RESERVED, 12'hFFF};
        row.typed = 1'b0;
        row.want  = '0;
        opening_rows.push_back(row);
        row.item  = {OP_SAMPLE, 12'hA5A};
        opening_rows.push_back(row);
        row.item  = {OP_SAMPLE, 12'h5A5};
        opening_rows.push_back(row);

        foreach (opening_rows[k])
            send_item(opening_rows[k].item, opening_rows[k].typed, opening_rows[k].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                settle();
                case (ph)
                    1:
                    begin
                        write_reg(REG_LOW_THRESHOLD, '0);
                        write_reg(REG_NORMAL_THRESHOLD, '0);
                        write_reg(REG_CHARGE_THRESHOLD, '0);
                    end
                    2:
                    begin
                        write_reg(REG_LOW_THRESHOLD, FULL_LEVEL);
                        write_reg(REG_NORMAL_THRESHOLD, FULL_LEVEL);
                        write_reg(REG_CHARGE_THRESHOLD, FULL_LEVEL);
                    end
                    3:
                    begin
                        write_reg(REG_LOW_THRESHOLD, LEVEL_W'($urandom_range(300000, 360000)));
                        write_reg(REG_NORMAL_THRESHOLD,
                                  LEVEL_W'($urandom_range(360001, 400000)));
                        write_reg(REG_CHARGE_THRESHOLD,
                                  LEVEL_W'($urandom_range(400001, 450000)));
                    end
                    4:
                    begin
                        write_reg(REG_NONE, LEVEL_W'($urandom));
                        write_reg(REG_LOW_THRESHOLD, LEVEL_W'($urandom_range(0, FULL_LEVEL)));
                        write_reg(REG_NORMAL_THRESHOLD,
                                  LEVEL_W'($urandom_range(0, FULL_LEVEL)));
                        write_reg(REG_CHARGE_THRESHOLD,
                                  LEVEL_W'($urandom_range(0, FULL_LEVEL)));
                    end
                    default:
                    begin
                        write_reg(REG_LOW_THRESHOLD, LOW_THRESHOLD_RST);
                        write_reg(REG_NORMAL_THRESHOLD, NORMAL_THRESHOLD_RST);
                        write_reg(REG_CHARGE_THRESHOLD, FULL_LEVEL);
                        write_reg(REG_NONE, 20'hFFFFF);
                    end
                endcase
            end
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if (n % 64 == 0)
                begin
                    idle_in  = ($urandom_range(0, 3) != 0);
                    idle_out = ($urandom_range(0, 3) != 0);
                end
                // long output stall while input keeps coming back to back
                if (ph == 0 && n == 40 && !hold_out)
                begin
                    idle_in  = 1'b0;
                    hold_out = 1'b1;
                end
                it = rand_item();
                send_item(it, 1'b0, '0);
                if (it.operation != OP_RESERVED)
                    n++;
            end
        end

        settle();
        if (errors == 0 && pending_readings.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/core/blm_pkg.sv
rtl/core/blm_filter.sv
rtl/core/battery_level_monitor.sv
sim/tb_top.sv
